// ===== design/cbavg_pkg.sv =====
// Package for the UDP/CBOR value batch averager: constants, codes and the
// frame record that crosses from the parser to the accumulator. No dependencies.
package cbavg_pkg;

   localparam int unsigned LEN_W = 12;

   localparam logic [LEN_W-1:0] MAX_FRAME_BYTES = 12'd4095;
   localparam logic [LEN_W-1:0] HDR_BYTES       = 12'd58;

   // Byte offsets of the checked fields
   localparam logic [LEN_W-1:0] OFF_ETH_HI = 12'd12;
   localparam logic [LEN_W-1:0] OFF_ETH_LO = 12'd13;
   localparam logic [LEN_W-1:0] OFF_PROTO  = 12'd23;
   localparam logic [LEN_W-1:0] OFF_ARRAY  = 12'd55;
   localparam logic [LEN_W-1:0] OFF_OPER   = 12'd56;
   localparam logic [LEN_W-1:0] OFF_SAMPLE = 12'd57;

   localparam logic [7:0] ETH_HI_VAL   = 8'h08;
   localparam logic [7:0] ETH_LO_VAL   = 8'h00;
   localparam logic [7:0] PROTO_UDP    = 8'd17;
   localparam logic [3:0] ARRAY_NIBBLE = 4'h8;
   localparam logic [7:0] OPER_IN      = 8'd1;
   localparam logic [7:0] OPER_AVERAGE = 8'd3;

   localparam logic [7:0] BATCH_RESET = 8'd10;

   localparam logic [1:0] VERDICT_PASS    = 2'd0;
   localparam logic [1:0] VERDICT_DROP    = 2'd1;
   localparam logic [1:0] VERDICT_REWRITE = 2'd2;

   localparam int unsigned DIV_STEPS = 16;

   typedef struct packed {
      logic             qualifies;
      logic [LEN_W-1:0] length;
      logic [7:0]       sample;
   } frame_rec_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

// ===== design/cbavg_ifs.sv =====
// Valid/ready channel interfaces for the byte input and the verdict output.
// Depends on nothing.
interface cbavg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, frame_byte, frame_end, input ready);
   modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface cbavg_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [7:0]  new_operation;
   logic [7:0]  new_value;
   logic [11:0] new_length;

   modport source (output valid, verdict, new_operation, new_value, new_length,
                   input ready);
   modport sink   (input valid, verdict, new_operation, new_value, new_length,
                   output ready);
endinterface

// ===== design/cbavg_front.sv =====
// Byte parser: tracks offset and header checks, emits one frame record at
// frame end. Depends on cbavg_pkg and cbavg_req_if.
module cbavg_front (
   input  logic                     clock,
   input  logic                     reset,
   cbavg_req_if.sink                req_bus,
   input  logic                     q_full,
   output logic                     q_push,
   output cbavg_pkg::frame_rec_type q_rec
);
   import cbavg_pkg::*;

   logic [LEN_W-1:0] off_ff, off_in;
   logic             eth_ff, eth_in;
   logic             proto_ff, proto_in;
   logic             array_ff, array_in;
   logic             oper_ff, oper_in;
   logic [7:0]       sample_ff, sample_in;
   logic             take;

   assign req_bus.ready = !q_full;
   assign take          = req_bus.valid && !q_full;

   always_comb begin
      eth_in    = eth_ff;
      proto_in  = proto_ff;
      array_in  = array_ff;
      oper_in   = oper_ff;
      sample_in = sample_ff;
      case (off_ff)
         OFF_ETH_HI: eth_in    = (req_bus.frame_byte == ETH_HI_VAL);
         OFF_ETH_LO: eth_in    = eth_ff && (req_bus.frame_byte == ETH_LO_VAL);
         OFF_PROTO:  proto_in  = (req_bus.frame_byte == PROTO_UDP);
         OFF_ARRAY:  array_in  = (req_bus.frame_byte[7:4] == ARRAY_NIBBLE);
         OFF_OPER:   oper_in   = (req_bus.frame_byte == OPER_IN);
         OFF_SAMPLE: sample_in = req_bus.frame_byte;
         default: ;
      endcase
      off_in = (off_ff < MAX_FRAME_BYTES) ? off_ff + 12'd1 : off_ff;
   end

   assign q_push          = take && req_bus.frame_end;
   assign q_rec.qualifies = (off_in >= HDR_BYTES) && eth_in && proto_in &&
                            array_in && oper_in;
   assign q_rec.length    = off_in;
   assign q_rec.sample    = sample_in;

   always_ff @(posedge clock) begin
      if (reset || q_push) begin
         off_ff    <= '0;
         eth_ff    <= 1'b0;
         proto_ff  <= 1'b0;
         array_ff  <= 1'b0;
         oper_ff   <= 1'b0;
         sample_ff <= '0;
      end else if (take) begin
         off_ff    <= off_in;
         eth_ff    <= eth_in;
         proto_ff  <= proto_in;
         array_ff  <= array_in;
         oper_ff   <= oper_in;
         sample_ff <= sample_in;
      end
   end

endmodule

// ===== design/cbavg_queue.sv =====
// Two-entry queue of frame records between parser and accumulator.
// Depends on cbavg_pkg.
module cbavg_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cbavg_pkg::frame_rec_type push_rec,
   input  logic                     pop,
   output cbavg_pkg::frame_rec_type pop_rec,
   output logic                     full,
   output logic                     empty
);
   import cbavg_pkg::*;

   frame_rec_type mem_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_rec = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== design/cbavg_back.sv =====
// Accumulator and serial divider: turns frame records into verdict words.
// Depends on cbavg_pkg and cbavg_rsp_if.
module cbavg_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               batch_size,
   input  logic                     q_empty,
   input  cbavg_pkg::frame_rec_type q_rec,
   output logic                     q_pop,
   cbavg_rsp_if.source              rsp_bus
);
   import cbavg_pkg::*;

   back_state_type   state_ff, state_in;
   logic [7:0]       seen_ff, seen_in;
   logic [15:0]      total_ff, total_in;
   logic [15:0]      quot_ff, quot_in;
   logic [7:0]       rem_ff, rem_in;
   logic [7:0]       div_ff, div_in;
   logic [3:0]       step_ff, step_in;
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_verdict_ff, out_verdict_in;
   logic [7:0]       out_oper_ff, out_oper_in;
   logic [7:0]       out_value_ff, out_value_in;
   logic [LEN_W-1:0] out_len_ff, out_len_in;

   logic             out_free;
   logic [7:0]       div_eff;
   logic [7:0]       seen_inc;
   logic [15:0]      total_add;
   logic [8:0]       rem_sh;
   logic [8:0]       rem_sub;

   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign div_eff   = (batch_size == 8'd0) ? 8'd1 : batch_size;
   assign seen_inc  = seen_ff + 8'd1;
   assign total_add = total_ff + {8'd0, q_rec.sample};
   assign rem_sh    = {rem_ff, quot_ff[15]};
   assign rem_sub   = rem_sh - {1'b0, div_ff};

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.verdict       = out_verdict_ff;
   assign rsp_bus.new_operation = out_oper_ff;
   assign rsp_bus.new_value     = out_value_ff;
   assign rsp_bus.new_length    = out_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         seen_ff      <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff        <= quot_in;
      rem_ff         <= rem_in;
      div_ff         <= div_in;
      step_ff        <= step_in;
      out_verdict_ff <= out_verdict_in;
      out_oper_ff    <= out_oper_in;
      out_value_ff   <= out_value_in;
      out_len_ff     <= out_len_in;
   end

   always_comb begin
      state_in       = state_ff;
      seen_in        = seen_ff;
      total_in       = total_ff;
      quot_in        = quot_ff;
      rem_in         = rem_ff;
      div_in         = div_ff;
      step_in        = step_ff;
      out_valid_in   = out_valid_ff && !rsp_bus.ready;
      out_verdict_in = out_verdict_ff;
      out_oper_in    = out_oper_ff;
      out_value_in   = out_value_ff;
      out_len_in     = out_len_ff;
      q_pop          = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop          = 1'b1;
               out_verdict_in = VERDICT_PASS;
               out_oper_in    = '0;
               out_value_in   = '0;
               out_len_in     = q_rec.length;
               if (q_rec.qualifies && seen_inc >= div_eff) begin
                  // batch complete: divide the total, clear the batch
                  seen_in  = '0;
                  total_in = '0;
                  quot_in  = total_add;
                  rem_in   = '0;
                  div_in   = div_eff;
                  step_in  = '0;
                  state_in = BK_DIV;
               end else begin
                  if (q_rec.qualifies) begin
                     seen_in        = seen_inc;
                     total_in       = total_add;
                     out_verdict_in = VERDICT_DROP;
                  end
                  out_valid_in = 1'b1;
               end
            end
         end
         BK_DIV: begin
            if (rem_sh >= {1'b0, div_ff}) begin
               rem_in  = rem_sub[7:0];
               quot_in = {quot_ff[14:0], 1'b1};
            end else begin
               rem_in  = rem_sh[7:0];
               quot_in = {quot_ff[14:0], 1'b0};
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(DIV_STEPS - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_verdict_in = VERDICT_REWRITE;
               out_oper_in    = OPER_AVERAGE;
               out_value_in   = quot_ff[7:0];
               out_len_in     = HDR_BYTES;
               state_in       = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

endmodule

// ===== design/udp_cbor_value_batch_averager.sv =====
// Top level of the UDP/CBOR value batch averager: parser, record queue and
// accumulator/divider. Depends on cbavg_pkg, the channel interfaces and submodules.
//
//  Channel   Direction  Word                                          Handshake
//  req_bus   in         frame_byte[7:0], frame_end                    valid/ready
//  rsp_bus   out        verdict, new_operation, new_value, new_length valid/ready
//  csr_*     in         batch_size[7:0]                               write enable
//
// The parser takes one byte per cycle and hands a record to a two-entry queue
// on each frame_end byte; it stalls only when that queue is full.
// A pass or drop verdict is registered and leaves the back end in the cycle after its
// record is popped; a completed batch runs a 16-step restoring divider.
// Reset is synchronous: it clears the queue, counters, the output valid and sets
// batch_size to 10. A stalled output word holds while the parser keeps going.
module udp_cbor_value_batch_averager (
   input  logic        clock,
   input  logic        reset,
   cbavg_req_if.sink   req_bus,
   cbavg_rsp_if.source rsp_bus,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import cbavg_pkg::*;

   logic [7:0]    batch_size_ff, batch_size_in;
   logic          q_push, q_pop, q_full, q_empty;
   frame_rec_type push_rec, pop_rec;

   // Hold batch size unless written
   assign batch_size_in = csr_wr_en ? csr_wr_data : batch_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_size_ff <= BATCH_RESET;
      end else begin
         batch_size_ff <= batch_size_in;
      end
   end

   cbavg_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .q_full (q_full),
      .q_push (q_push),
      .q_rec  (push_rec)
   );

   cbavg_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_rec(push_rec),
      .pop     (q_pop),
      .pop_rec (pop_rec),
      .full    (q_full),
      .empty   (q_empty)
   );

   cbavg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .batch_size(batch_size_ff),
      .q_empty   (q_empty),
      .q_rec     (pop_rec),
      .q_pop     (q_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== design/cbavg_checker.sv =====
// Port-level checks on the verdict channel, bound to the top level.
// Depends on cbavg_pkg.
module cbavg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  verdict,
   input logic [7:0]  new_operation,
   input logic [7:0]  new_value,
   input logic [11:0] new_length
);
   import cbavg_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(verdict))
      else $error("verdict word dropped while stalled");

   a_rewrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && verdict == VERDICT_REWRITE |->
         new_operation == OPER_AVERAGE && new_length == HDR_BYTES)
      else $error("rewrite word without average header");

   a_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (verdict == VERDICT_PASS || verdict == VERDICT_DROP) |->
         new_operation == 8'd0 && new_value == 8'd0)
      else $error("pass or drop word carries rewrite fields");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> verdict != 2'd3)
      else $error("undefined verdict code");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word valid after reset");

endmodule

bind udp_cbor_value_batch_averager cbavg_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .verdict      (rsp_bus.verdict),
   .new_operation(rsp_bus.new_operation),
   .new_value    (rsp_bus.new_value),
   .new_length   (rsp_bus.new_length)
);

// ===== tb/sv/tb_udp_cbor_value_batch_averager.sv =====
// Testbench for udp_cbor_value_batch_averager: directed and random frame traffic
// with a bit-accurate verdict predictor and an in-order result checker.
// Depends on cbavg_pkg, the channel interfaces in cbavg_ifs.sv and the block itself.
module tb_udp_cbor_value_batch_averager;
   import cbavg_pkg::*;

   // Timeout limit.
   localparam int unsigned CYCLE_LIMIT  = 4_000_000;
   // Extra wait after every verdict due has arrived.
   localparam int unsigned DRAIN_CYCLES = 24;

   // How a generated frame departs from a qualifying one.
   typedef enum int {
      FLAW_NONE,
      FLAW_ETH_HI,
      FLAW_ETH_LO,
      FLAW_PROTO,
      FLAW_ARRAY,
      FLAW_OPER,
      FLAW_NOISE
   } frame_flaw_type;

   typedef struct packed {
      logic [1:0]       verdict;
      logic [7:0]       new_operation;
      logic [7:0]       new_value;
      logic [LEN_W-1:0] new_length;
   } verdict_word_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   cbavg_req_if req_bus ();
   cbavg_rsp_if rsp_bus ();

   udp_cbor_value_batch_averager u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: the batch register plus the per-frame field checks and
   // the per-batch accumulator, kept at the block's own widths.
   logic [7:0]       batch_size;
   logic [LEN_W-1:0] byte_count;
   logic             ethertype_seen;
   logic             udp_seen;
   logic             array_seen;
   logic             oper_seen;
   logic [7:0]       sample_val;
   logic [7:0]       frames_in_batch;
   logic [15:0]      sample_sum;

   verdict_word_type verdicts_due[$];   // verdicts still to come, oldest first
   verdict_word_type due_word;
   logic [7:0]       frame_buf[$];      // bytes of the frame being sent

   int          mismatch_count = 0;
   int unsigned cycle_count    = 0;
   bit          steady_input;           // set for frames sent with no gaps

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_udp_cbor_value_batch_averager NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      // Hold the log short if something is badly broken; keep counting.
      if (mismatch_count < 100)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic void clear_frame_checks();
      byte_count     = '0;
      ethertype_seen = 1'b0;
      udp_seen       = 1'b0;
      array_seen     = 1'b0;
      oper_seen      = 1'b0;
      sample_val     = '0;
   endfunction

   // Advance the predictor by one accepted frame byte. On the last byte of a
   // frame, decide the verdict and queue the word the block must produce.
   task automatic track_frame_byte(input logic [7:0] b, input logic last);
      verdict_word_type w;
      logic [7:0]       divisor;
      logic [15:0]      quotient;
      logic             qualifies;

      case (byte_count)
         OFF_ETH_HI: ethertype_seen = (b == ETH_HI_VAL);
         OFF_ETH_LO: ethertype_seen = ethertype_seen && (b == ETH_LO_VAL);
         OFF_PROTO:  udp_seen       = (b == PROTO_UDP);
         OFF_ARRAY:  array_seen     = (b[7:4] == ARRAY_NIBBLE);
         OFF_OPER:   oper_seen      = (b == OPER_IN);
         OFF_SAMPLE: sample_val     = b;
         default: ;
      endcase

      // Saturate the length; the frame still ends only at its end mark.
      if (byte_count < MAX_FRAME_BYTES)
         byte_count = byte_count + 12'd1;

      if (last) begin
         w.verdict       = VERDICT_PASS;
         w.new_operation = '0;
         w.new_value     = '0;
         w.new_length    = byte_count;

         qualifies = (byte_count >= HDR_BYTES) && ethertype_seen && udp_seen &&
                     array_seen && oper_seen;

         if (qualifies) begin
            // A zero batch size counts as one.
            divisor         = (batch_size == 8'd0) ? 8'd1 : batch_size;
            frames_in_batch = frames_in_batch + 8'd1;
            sample_sum      = sample_sum + {8'd0, sample_val};
            // A count at or above the size emits, also after the size was lowered.
            if (frames_in_batch >= divisor) begin
               quotient        = sample_sum / {8'd0, divisor};
               w.verdict       = VERDICT_REWRITE;
               w.new_operation = OPER_AVERAGE;
               w.new_value     = quotient[7:0];
               w.new_length    = HDR_BYTES;
               frames_in_batch = '0;
               sample_sum      = '0;
            end else begin
               w.verdict = VERDICT_DROP;
            end
         end

         verdicts_due.push_back(w);
         clear_frame_checks();
      end
   endtask

   // Mostly back-to-back bytes, some short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      if (steady_input)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // Offer one word and hold it until the block takes it. Valid stays high on
   // return so that a following word goes out with no bubble.
   task automatic send_word(input logic [7:0] b, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.frame_byte <= b;
      req_bus.frame_end  <= last;
      do
         @(posedge clock);
      while (!req_bus.ready);
      track_frame_byte(b, last);
   endtask

   // Build a frame of len bytes around the checked fields, spoil one of them
   // as flaw says, and send it.
   task automatic send_frame(input int len, input logic [7:0] value,
                             input frame_flaw_type flaw);
      frame_buf.delete();
      repeat (len) frame_buf.push_back(8'($urandom_range(0, 255)));

      if (flaw != FLAW_NOISE) begin
         if (len > int'(OFF_ETH_HI))
            frame_buf[OFF_ETH_HI] = (flaw == FLAW_ETH_HI) ?
                                    ETH_HI_VAL ^ 8'($urandom_range(1, 255)) : ETH_HI_VAL;
         if (len > int'(OFF_ETH_LO))
            frame_buf[OFF_ETH_LO] = (flaw == FLAW_ETH_LO) ?
                                    ETH_LO_VAL ^ 8'($urandom_range(1, 255)) : ETH_LO_VAL;
         if (len > int'(OFF_PROTO))
            frame_buf[OFF_PROTO] = (flaw == FLAW_PROTO) ?
                                   PROTO_UDP ^ 8'($urandom_range(1, 255)) : PROTO_UDP;
         if (len > int'(OFF_ARRAY))
            frame_buf[OFF_ARRAY] = {(flaw == FLAW_ARRAY) ?
                                    ARRAY_NIBBLE ^ 4'($urandom_range(1, 15)) : ARRAY_NIBBLE,
                                    4'($urandom_range(0, 15))};
         if (len > int'(OFF_OPER))
            frame_buf[OFF_OPER] = (flaw == FLAW_OPER) ?
                                  OPER_IN ^ 8'($urandom_range(1, 255)) : OPER_IN;
         if (len > int'(OFF_SAMPLE))
            frame_buf[OFF_SAMPLE] = value;
      end

      // About one frame in four goes out with no gaps at all.
      steady_input = ($urandom_range(0, 3) == 0);
      foreach (frame_buf[i])
         send_word(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   // Drop valid, wait for every verdict due, then let the divider settle.
   task automatic pause_input();
      req_bus.valid <= 1'b0;
      while (verdicts_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the batch size, only with the block idle.
   task automatic set_batch_size(input logic [7:0] value);
      pause_input();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      batch_size = value;
   endtask

   // Reset batch size of ten, extreme samples, a one-byte frame and a frame
   // one byte short of qualifying.
   task automatic test_default_batch();
      send_frame(1, 8'h00, FLAW_NONE);
      send_frame(57, 8'hFF, FLAW_NONE);
      for (int i = 0; i < 10; i++)
         send_frame(58, (i < 5) ? 8'hFF : 8'h00, FLAW_NONE);
   endtask

   // With a batch of one, each broken field must turn the frame into a pass;
   // good frames rewrite at once, a longer one trimmed to the header length.
   task automatic test_field_checks();
      set_batch_size(8'd1);
      for (int f = FLAW_ETH_HI; f <= FLAW_OPER; f++)
         send_frame(58, 8'($urandom_range(0, 255)), frame_flaw_type'(f));
      send_frame(58, 8'hFF, FLAW_NONE);
      send_frame(60, 8'h00, FLAW_NONE);
      send_frame(20, 8'h5A, FLAW_NOISE);
   endtask

   // A zero batch size averages every qualifying frame on its own.
   task automatic test_zero_batch();
      set_batch_size(8'd0);
      send_frame(58, 8'hAB, FLAW_NONE);
      send_frame(58, 8'hFF, FLAW_NONE);
      send_frame(58, 8'h33, FLAW_OPER);
   endtask

   // Lower the size under a running count: the next qualifying frame emits
   // and the quotient wraps to its low byte.
   task automatic test_batch_lowered();
      set_batch_size(8'd255);
      repeat (2) send_frame(58, 8'hFF, FLAW_NONE);
      set_batch_size(8'd1);
      send_frame(58, 8'hFF, FLAW_NONE);
   endtask

   // Phases of mostly qualifying frames with random values, mixed with broken,
   // short and noise frames, under a new batch size each phase.
   task automatic test_random_traffic();
      int             frames_sent;
      int             bytes_sent;
      int             phase;
      int             len;
      int             r;
      frame_flaw_type flaw;

      frames_sent = 0;
      bytes_sent  = 0;
      phase       = 0;
      while (frames_sent < 6 || bytes_sent < 250) begin
         case (phase % 6)
            0: set_batch_size(8'd1);
            1: set_batch_size(8'($urandom_range(2, 4)));
            2: set_batch_size(8'd0);
            3: set_batch_size(8'($urandom_range(5, 8)));
            4: set_batch_size(8'd255);
            default: set_batch_size(8'($urandom_range(1, 255)));
         endcase
         repeat ($urandom_range(3, 6)) begin
            r    = $urandom_range(0, 99);
            len  = 58;
            flaw = FLAW_NONE;
            if (r < 65) begin
               if ($urandom_range(0, 3) == 0)
                  len = 58 + $urandom_range(1, 40);
            end else if (r < 82) begin
               flaw = frame_flaw_type'($urandom_range(FLAW_ETH_HI, FLAW_OPER));
            end else if (r < 91) begin
               len = $urandom_range(1, 57);
            end else begin
               flaw = FLAW_NOISE;
               len  = $urandom_range(1, 100);
            end
            send_frame(len, 8'($urandom_range(0, 255)), flaw);
            frames_sent++;
            bytes_sent += len;
         end
         phase++;
      end
   endtask

   // Result side: random stalls, mostly short, a few long, with stall-free
   // stretches in between.
   initial begin
      int hold;
      int r;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
               rsp_bus.ready <= 1'b1;
               hold = $urandom_range(20, 80);
            end else if (r < 75) begin
               rsp_bus.ready <= 1'b1;
               hold = $urandom_range(0, 4);
            end else if (r < 95) begin
               rsp_bus.ready <= 1'b0;
               hold = $urandom_range(0, 3);
            end else begin
               rsp_bus.ready <= 1'b0;
               hold = $urandom_range(10, 40);
            end
         end
      end
   end

   // Compare every accepted verdict word with the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (verdicts_due.size() == 0) begin
            report_mismatch($sformatf("word with nothing due: verdict %0d length %0d",
                                      rsp_bus.verdict, rsp_bus.new_length));
         end else begin
            due_word = verdicts_due.pop_front();
            if (rsp_bus.verdict !== due_word.verdict)
               report_mismatch($sformatf("verdict %0d, want %0d",
                                         rsp_bus.verdict, due_word.verdict));
            if (rsp_bus.new_operation !== due_word.new_operation)
               report_mismatch($sformatf("new_operation %0d, want %0d",
                                         rsp_bus.new_operation, due_word.new_operation));
            if (rsp_bus.new_value !== due_word.new_value)
               report_mismatch($sformatf("new_value %0d, want %0d",
                                         rsp_bus.new_value, due_word.new_value));
            if (rsp_bus.new_length !== due_word.new_length)
               report_mismatch($sformatf("new_length %0d, want %0d",
                                         rsp_bus.new_length, due_word.new_length));
         end
      end
   end

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.frame_byte <= '0;
      req_bus.frame_end  <= 1'b0;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      batch_size      = BATCH_RESET;
      frames_in_batch = '0;
      sample_sum      = '0;
      clear_frame_checks();
      steady_input    = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_default_batch();
      test_field_checks();
      test_zero_batch();
      test_batch_lowered();
      test_random_traffic();

      // Drain, then give stray words time to show up at the checker.
      pause_input();
      if (mismatch_count == 0)
         $display("tb_udp_cbor_value_batch_averager OK");
      else
         $display("tb_udp_cbor_value_batch_averager NOT OK");
      $finish;
   end

endmodule
